// ----- hdl/sha_pkg.sv -----
// Shared definitions for the streaming SHA-256 hasher: field widths, the
// initial hash value, the round constant table and the SHA-256 mixing functions.
// No dependencies.
package sha_pkg;

	localparam int WordW  = 32;
	localparam int CountW = 3;
	localparam int IndexW = 3;
	localparam int LenW   = 64;

	// Largest number of message bytes a single word can carry.
	localparam logic [CountW-1:0] MaxBytes = 3'd4;

	// First padding byte after the message.
	localparam logic [7:0] PadMark = 8'h80;

	// Block position at which the length field starts.
	localparam logic [5:0] LenStart = 6'd56;

	typedef logic [WordW-1:0] word_t;

	// Initial hash value, word 0 first.
	function automatic word_t init_h(input logic [IndexW-1:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round constant for round idx.
	function automatic word_t round_k(input logic [5:0] idx);
		word_t r;
		case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- hdl/sha256_stream_hasher.sv -----
// Streaming SHA-256 hasher: byte packing, padding, compression and digest output.
// Depends on sha_pkg for constants, the round constant table and mixing functions.
//
// The message enters as big-endian 32-bit words on the s_ channel; each transfer
// carries a count of valid leading bytes (saturated at four) and tlast on the final
// word, where a count of zero marks no further bytes, so a lone empty last word
// hashes the empty message. A small sequencer packs one byte per clock, outside
// compression, into a 512-bit block window; the next transfer is accepted only once
// all bytes of the word are placed. Each full 64-byte block then runs through one
// shared round unit, one round per clock, and a final step folds the result into the
// chaining value; meanwhile s_tready is low. On the last word the padding is inserted
// one byte per clock outside compression (9 to 72 bytes, with a second block when
// needed), after which the eight digest words leave on the m_ channel, word 0 first,
// with tlast on word 7. The block then returns to its initial state.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	// Message input channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] message_word, [34:32] valid_bytes, zero fill
	input  logic        s_tlast,   // last_word
	// Digest output channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_tlast    // digest_last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BYTE = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_COMP = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                   state_q;
	logic [2:0]                   ret_q;
	logic [31:0]                  word_q;
	logic [sha_pkg::CountW-1:0]   cnt_q;
	logic                         last_q;
	logic [5:0]                   fill_q;
	logic [sha_pkg::LenW-1:0]     bitlen_q;
	logic                         mark_sent_q;
	logic [2:0]                   len_idx_q;
	logic [5:0]                   rnd_q;
	logic [sha_pkg::IndexW-1:0]   out_idx_q;
	logic [511:0]                 win_q;
	sha_pkg::word_t               chain_q [8];
	sha_pkg::word_t               var_q [8];

	logic                         s_xfer;
	logic                         m_xfer;
	logic [sha_pkg::CountW-1:0]   in_cnt;
	logic                         put_en;
	logic [7:0]                   put_byte;
	logic                         blk_full;
	logic                         len_phase;
	logic [2:0]                   after_put;
	sha_pkg::word_t               t1;
	sha_pkg::word_t               t2;
	sha_pkg::word_t               w_new;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_xfer   = m_tvalid && m_tready;
	assign m_tdata  = {5'b0, out_idx_q, chain_q[out_idx_q]};
	assign m_tlast  = (out_idx_q == 3'd7);

	// Byte count of the incoming word, with counts above four saturated.
	assign in_cnt = (s_tdata[34:32] > sha_pkg::MaxBytes) ? sha_pkg::MaxBytes
		: s_tdata[34:32];

	// Length bytes follow once the mark is in and the block reaches the length field.
	assign len_phase = mark_sent_q && ((fill_q == sha_pkg::LenStart) || (len_idx_q != 3'd0));

	// Select the byte placed this cycle and the state that follows it.
	always_comb begin
		put_en    = 1'b0;
		put_byte  = 8'h00;
		after_put = state_q;
		case (state_q)
			ST_BYTE: begin
				put_en   = 1'b1;
				put_byte = word_q[31:24];
				if (cnt_q != 3'd1) begin
					after_put = ST_BYTE;
				end else if (last_q) begin
					after_put = ST_PAD;
				end else begin
					after_put = ST_IDLE;
				end
			end
			ST_PAD: begin
				put_en = 1'b1;
				if (!mark_sent_q) begin
					put_byte  = sha_pkg::PadMark;
					after_put = ST_PAD;
				end else if (len_phase) begin
					put_byte  = bitlen_q[63:56];
					after_put = (len_idx_q == 3'd7) ? ST_OUT : ST_PAD;
				end else begin
					put_byte  = 8'h00;
					after_put = ST_PAD;
				end
			end
			default: begin
				put_en    = 1'b0;
				put_byte  = 8'h00;
				after_put = state_q;
			end
		endcase
	end

	assign blk_full = put_en && (fill_q == 6'd63);

	// Shared round unit and message schedule step.
	always_comb begin
		t1 = var_q[7] + sha_pkg::big_sigma1(var_q[4])
			+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
			+ sha_pkg::round_k(rnd_q) + win_q[511:480];
		t2 = sha_pkg::big_sigma0(var_q[0])
			+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
		w_new = win_q[511:480] + sha_pkg::small_sigma0(win_q[479:448])
			+ win_q[223:192] + sha_pkg::small_sigma1(win_q[63:32]);
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			fill_q      <= '0;
			bitlen_q    <= '0;
			mark_sent_q <= 1'b0;
			len_idx_q   <= '0;
			rnd_q       <= '0;
			out_idx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha_pkg::init_h(3'(i));
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						cnt_q  <= in_cnt;
						last_q <= s_tlast;
						if (in_cnt != 3'd0) begin
							state_q <= ST_BYTE;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_BYTE, ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (state_q == ST_BYTE) begin
						cnt_q    <= cnt_q - 3'd1;
						bitlen_q <= bitlen_q + 64'd8;
					end else if (!mark_sent_q) begin
						mark_sent_q <= 1'b1;
					end else if (len_phase) begin
						bitlen_q  <= {bitlen_q[55:0], 8'h00};
						len_idx_q <= len_idx_q + 3'd1;
					end
					if (blk_full) begin
						state_q <= ST_COMP;
						ret_q   <= after_put;
						rnd_q   <= '0;
					end else begin
						state_q <= after_put;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (m_xfer) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= sha_pkg::init_h(3'(i));
							end
							bitlen_q    <= '0;
							fill_q      <= '0;
							mark_sent_q <= 1'b0;
							len_idx_q   <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Block window, word holding register and working variables.
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			word_q <= s_tdata[31:0];
		end else if (state_q == ST_BYTE) begin
			word_q <= {word_q[23:0], 8'h00};
		end
		if (put_en) begin
			win_q <= {win_q[503:0], put_byte};
		end else if (state_q == ST_COMP) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (blk_full) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_COMP) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

endmodule
